[sv/pidvi_pkg.sv]
// ----------------------------------------------------------------------------
// PID controller package
// Widths, register indexes, term codes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package pidvi_pkg;

    // Parameter defaults for the top level.
    localparam int CHANNELS_DEF  = 2;
    localparam int FRAC_BITS_DEF = 16;
    localparam int SUM_LIMIT_DEF = 1500;

    // Fixed field widths.
    localparam int GAIN_W    = 16;
    localparam int SAMPLE_W  = 16;
    localparam int TS_W      = 32;
    localparam int ERR_W     = SAMPLE_W + 1;
    localparam int ESUM_W    = 32;
    localparam int DRIVE_W   = 40;
    localparam int CFG_IDX_W = 3;

    // Internal widths.
    localparam int EDT_W  = ERR_W + TS_W + 1;       // error times interval
    localparam int DE_W   = 32;                     // error change times 10000
    localparam int ABS_W  = 31;                     // magnitude of DE and the sum
    localparam int PMAG_W = GAIN_W + ERR_W;
    localparam int MAG_W  = GAIN_W + ABS_W;
    localparam int DEN_W  = TS_W + 1;               // doubled divisor
    localparam int Q_W    = 42;                     // quotient bits, even
    localparam int TERM_W = DRIVE_W + 1;            // term magnitude, capped at 2^40
    localparam int ACC_W  = DRIVE_W + 3;

    localparam longint US_PER_S = 1000000;
    localparam logic [TS_W-1:0] P_DEN = TS_W'(100);
    localparam logic [TS_W-1:0] I_DEN = TS_W'(100000000);
    localparam logic [DE_W-1:0] DE_SCALE = DE_W'(10000);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_CH0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I_CH0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_CH0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_CH1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I_CH1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_CH1 = 3'd5;

    typedef logic [1:0] t_term;
    localparam t_term TERM_P = 2'd0;
    localparam t_term TERM_I = 2'd1;
    localparam t_term TERM_D = 2'd2;

    typedef struct packed {
        logic  accept;
        logic  mul;
        logic  sum;
        logic  imul;
        logic  div_load;
        logic  div_start;
        logic  acc;
        logic  store;
        t_term term;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic zero;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

[sv/pidvi_div.sv]
// ----------------------------------------------------------------------------
// PID term divider
// Restoring divider, two quotient bits per cycle, result capped at 2^40.
// ----------------------------------------------------------------------------
`default_nettype none

module pidvi_div
    import pidvi_pkg::*;
#(
    parameter int N_W = 65
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [N_W-1:0]    i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    output logic                   o_done,
    output logic [TERM_W-1:0]      o_quo
);

    localparam int STEPS = Q_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int REM_W = DEN_W + 1;
    localparam logic [TERM_W-1:0] CAP = {1'b1, {(TERM_W-1){1'b0}}};

    function automatic logic [REM_W:0] div_bit(input logic [REM_W-1:0] rem,
                                               input logic b,
                                               input logic [DEN_W-1:0] den);
        logic [REM_W-1:0] t;
        t = {rem[REM_W-2:0], b};
        if (t >= REM_W'(den)) begin
            return {1'b1, t - REM_W'(den)};
        end
        return {1'b0, t};
    endfunction

    logic [REM_W-1:0] r_rem;
    logic [Q_W-1:0]   r_num;
    logic [Q_W-1:0]   r_quo;
    logic [DEN_W-1:0] r_den;
    logic             r_ovf;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [N_W-Q_W-1:0] w_top;
    logic [REM_W:0]     w_s1;
    logic [REM_W:0]     w_s2;

    assign w_top = i_num[N_W-1:Q_W];
    assign w_s1  = div_bit(r_rem, r_num[Q_W-1], r_den);
    assign w_s2  = div_bit(w_s1[REM_W-1:0], r_num[Q_W-2], r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // The quotient cannot fit Q_W bits when the top part reaches the divisor.
            r_ovf <= REM_W'(w_top) >= REM_W'(i_den);
            r_rem <= REM_W'(w_top);
            r_num <= i_num[Q_W-1:0];
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_s2[REM_W-1:0];
            r_num <= {r_num[Q_W-3:0], 2'b00};
            r_quo <= {r_quo[Q_W-3:0], w_s1[REM_W], w_s2[REM_W]};
        end
    end

    assign o_done = r_done;
    assign o_quo  = (r_ovf || r_quo > Q_W'(CAP)) ? CAP : r_quo[TERM_W-1:0];

endmodule

`default_nettype wire

[sv/pidvi_dp.sv]
// ----------------------------------------------------------------------------
// PID datapath
// Gains, channel state, multipliers, term accumulator and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pidvi_dp
    import pidvi_pkg::*;
#(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SUM_LIMIT = SUM_LIMIT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [GAIN_W-1:0]     i_cfg_data,
    input  wire logic [63:0]           i_s_tdata,
    input  wire logic                  i_s_tuser,
    input  wire logic                  i_m_tready,
    output logic                       o_m_tvalid,
    output logic [DRIVE_W-1:0]         o_m_tdata,
    output logic [1:0]                 o_m_tuser,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SUM_W = EDT_W + 1;
    localparam int N_W   = MAG_W + FRAC_BITS + 2;
    localparam longint LIMIT_L = longint'(SUM_LIMIT) * US_PER_S;
    localparam logic signed [SUM_W-1:0] LIMIT = SUM_W'(LIMIT_L);

    // Configuration
    logic [GAIN_W-1:0] r_gain_p [2];
    logic [GAIN_W-1:0] r_gain_i [2];
    logic [GAIN_W-1:0] r_gain_d [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 2; k++) begin
                r_gain_p[k] <= '0;
                r_gain_i[k] <= '0;
                r_gain_d[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GAIN_P_CH0: r_gain_p[0] <= i_cfg_data;
                REG_GAIN_I_CH0: r_gain_i[0] <= i_cfg_data;
                REG_GAIN_D_CH0: r_gain_d[0] <= i_cfg_data;
                REG_GAIN_P_CH1: r_gain_p[1] <= i_cfg_data;
                REG_GAIN_I_CH1: r_gain_i[1] <= i_cfg_data;
                REG_GAIN_D_CH1: r_gain_d[1] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Channel state
    logic [TS_W-1:0]          r_last_time [CHANNELS];
    logic signed [ERR_W-1:0]  r_last_err  [CHANNELS];
    logic signed [ESUM_W-1:0] r_err_sum   [CHANNELS];

    // Item registers
    logic [CH_W-1:0]          r_idx;
    logic [GAIN_W-1:0]        r_gp;
    logic [GAIN_W-1:0]        r_gi;
    logic [GAIN_W-1:0]        r_gd;
    logic signed [ERR_W-1:0]  r_e;
    logic signed [ERR_W-1:0]  r_le;
    logic signed [ESUM_W-1:0] r_es;
    logic [TS_W-1:0]          r_dt;
    logic [TS_W-1:0]          r_now;
    logic                     r_zero;
    logic signed [EDT_W-1:0]  r_edt;
    logic signed [DE_W-1:0]   r_de;
    logic [PMAG_W-1:0]        r_pmag;
    logic signed [ESUM_W-1:0] r_sum;
    logic [MAG_W-1:0]         r_dmag;
    logic [MAG_W-1:0]         r_imag;
    logic [N_W-1:0]           r_num;
    logic [DEN_W-1:0]         r_den2;
    logic                     r_neg;
    logic signed [ACC_W-1:0]  r_acc;

    logic [CH_W-1:0]          w_idx;
    logic signed [ERR_W-1:0]  w_e;
    logic [TS_W-1:0]          w_dt;
    logic [ERR_W-1:0]         w_e_abs;
    logic signed [ERR_W:0]    w_de_raw;
    logic signed [EDT_W-1:0]  n_edt;
    logic signed [DE_W-1:0]   n_de;
    logic [PMAG_W-1:0]        n_pmag;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [SUM_W-1:0]  w_sum_clamp;
    logic [ABS_W-1:0]         w_de_abs;
    logic [ABS_W-1:0]         w_sum_abs;
    logic [MAG_W-1:0]         n_dmag;
    logic [MAG_W-1:0]         n_imag;
    logic [MAG_W-1:0]         w_mag;
    logic [TS_W-1:0]          w_den;
    logic                     w_neg;
    logic [TERM_W-1:0]        w_quo;
    logic                     w_div_done;
    logic signed [ACC_W-1:0]  w_term;
    logic                     w_fits;
    logic [DRIVE_W-1:0]       w_drive;

    assign w_idx = (CHANNELS == 1) ? '0 : CH_W'(i_s_tuser);
    assign w_e   = ERR_W'($signed(i_s_tdata[15:0])) - ERR_W'($signed(i_s_tdata[31:16]));
    assign w_dt  = i_s_tdata[63:32] - r_last_time[w_idx];

    assign w_e_abs  = r_e[ERR_W-1] ? ERR_W'(-r_e) : ERR_W'(r_e);
    assign w_de_raw = (ERR_W+1)'(r_e) - (ERR_W+1)'(r_le);
    assign n_edt    = r_e * $signed({1'b0, r_dt});
    assign n_de     = DE_W'(w_de_raw) * $signed(DE_SCALE);
    assign n_pmag   = r_gp * w_e_abs;

    assign w_sum = SUM_W'(r_es) + SUM_W'(r_edt);
    always_comb begin
        if (w_sum > LIMIT) begin
            w_sum_clamp = LIMIT;
        end else if (w_sum < -LIMIT) begin
            w_sum_clamp = -LIMIT;
        end else begin
            w_sum_clamp = w_sum;
        end
    end
    assign w_de_abs  = r_de[DE_W-1] ? ABS_W'(-r_de) : ABS_W'(r_de);
    assign w_sum_abs = r_sum[ESUM_W-1] ? ABS_W'(-r_sum) : ABS_W'(r_sum);
    assign n_dmag    = r_gd * w_de_abs;
    assign n_imag    = r_gi * w_sum_abs;

    always_comb begin
        case (i_cmd.term)
            TERM_P: begin
                w_mag = MAG_W'(r_pmag);
                w_den = P_DEN;
                w_neg = r_e[ERR_W-1];
            end
            TERM_I: begin
                w_mag = r_imag;
                w_den = I_DEN;
                w_neg = r_sum[ESUM_W-1];
            end
            default: begin
                w_mag = r_dmag;
                w_den = r_dt;
                w_neg = r_de[DE_W-1];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx  <= w_idx;
            r_gp   <= r_gain_p[i_s_tuser];
            r_gi   <= r_gain_i[i_s_tuser];
            r_gd   <= r_gain_d[i_s_tuser];
            r_e    <= w_e;
            r_le   <= r_last_err[w_idx];
            r_es   <= r_err_sum[w_idx];
            r_dt   <= w_dt;
            r_now  <= i_s_tdata[63:32];
            r_zero <= (w_dt == '0);
        end
        if (i_cmd.mul) begin
            r_edt  <= n_edt;
            r_de   <= n_de;
            r_pmag <= n_pmag;
        end
        if (i_cmd.sum) begin
            r_sum  <= ESUM_W'(w_sum_clamp);
            r_dmag <= n_dmag;
        end
        if (i_cmd.imul) begin
            r_imag <= n_imag;
        end
        if (i_cmd.div_load) begin
            // Rounded quotient: (mag * 2^(F+1) + den) / (2 * den).
            r_num  <= (N_W'(w_mag) << (FRAC_BITS + 1)) + N_W'(w_den);
            r_den2 <= {w_den, 1'b0};
            r_neg  <= w_neg;
        end
    end

    pidvi_div #(
        .N_W (N_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_num),
        .i_den   (r_den2),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign w_term = r_neg ? -$signed(ACC_W'(w_quo)) : $signed(ACC_W'(w_quo));

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_acc <= '0;
        end else if (i_cmd.acc) begin
            r_acc <= r_acc + w_term;
        end
    end

    // The sum fits when its bits above the drive's sign bit all repeat the sign.
    assign w_fits = (r_acc[ACC_W-1:DRIVE_W-1] == '0) || (r_acc[ACC_W-1:DRIVE_W-1] == '1);
    always_comb begin
        if (w_fits) begin
            w_drive = r_acc[DRIVE_W-1:0];
        end else if (r_acc[ACC_W-1]) begin
            w_drive = {1'b1, {(DRIVE_W-1){1'b0}}};
        end else begin
            w_drive = {1'b0, {(DRIVE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_last_time[c] <= '0;
                r_last_err[c]  <= '0;
                r_err_sum[c]   <= '0;
            end
        end else if (i_cmd.store) begin
            r_last_time[r_idx] <= r_now;
            r_last_err[r_idx]  <= r_e;
            r_err_sum[r_idx]   <= r_sum;
        end
    end

    // Output register
    logic                 r_m_tvalid;
    logic [DRIVE_W-1:0]   r_m_tdata;
    logic [1:0]           r_m_tuser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (i_cmd.store) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_m_tdata <= w_drive;
            r_m_tuser <= {r_zero, !w_fits};
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

    assign o_sts.div_done = w_div_done;
    assign o_sts.zero     = r_zero;
    assign o_sts.out_free = !r_m_tvalid || i_m_tready;

endmodule

`default_nettype wire

[sv/pidvi_ctrl.sv]
// ----------------------------------------------------------------------------
// PID controller sequencer
// Steps one sample through the multiplies and up to three term divisions.
// ----------------------------------------------------------------------------
`default_nettype none

module pidvi_ctrl
    import pidvi_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_s_tvalid,
    output logic       o_s_tready,
    input  wire t_sts  i_sts,
    output t_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL    = 4'd1;
    localparam logic [3:0] S_SUM    = 4'd2;
    localparam logic [3:0] S_IMUL   = 4'd3;
    localparam logic [3:0] S_DLOAD  = 4'd4;
    localparam logic [3:0] S_DSTART = 4'd5;
    localparam logic [3:0] S_DRUN   = 4'd6;
    localparam logic [3:0] S_DACC   = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_term      r_term;
    t_term      n_term;

    always_comb begin
        n_state    = r_state;
        n_term     = r_term;
        o_cmd      = '0;
        o_cmd.term = r_term;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_IMUL;
            end
            S_IMUL: begin
                o_cmd.imul = 1'b1;
                n_term     = TERM_P;
                n_state    = S_DLOAD;
            end
            S_DLOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DRUN;
            end
            S_DRUN: begin
                if (i_sts.div_done) begin
                    n_state = S_DACC;
                end
            end
            S_DACC: begin
                o_cmd.acc = 1'b1;
                case (r_term)
                    TERM_P: begin
                        n_term  = TERM_I;
                        n_state = S_DLOAD;
                    end
                    TERM_I: begin
                        // A zero interval drops the derivative term.
                        if (i_sts.zero) begin
                            n_state = S_OUT;
                        end else begin
                            n_term  = TERM_D;
                            n_state = S_DLOAD;
                        end
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.store = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_term  <= TERM_P;
        end else begin
            r_state <= n_state;
            r_term  <= n_term;
        end
    end

endmodule

`default_nettype wire

[sv/pid_variable_interval_top.sv]
// ----------------------------------------------------------------------------
// Variable-interval PID controller
// Up to two channels; P, I and D terms in fixed point, summed and saturated.
// ----------------------------------------------------------------------------
// A new input transfer is taken only after the previous result has entered the output register;
// a zero interval skips the derivative term. Each term runs in the shared divider at two
// quotient bits per cycle.
// A finished result waits in the output register; the next one is held until it leaves.
// Reset (synchronous, active low) clears gains, channel state and the handshakes.
`default_nettype none

module pid_variable_interval_top
    import pidvi_pkg::*;
#(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SUM_LIMIT = SUM_LIMIT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [GAIN_W-1:0]     i_cfg_data,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [63:0]           i_s_axis_tdata,  // setpoint, measured, timestamp_us
    input  wire logic [0:0]            i_s_axis_tuser,  // channel
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [DRIVE_W-1:0]         o_m_axis_tdata,  // drive
    output logic [1:0]                 o_m_axis_tuser   // drive_saturated, zero_interval
);

    t_cmd w_cmd;
    t_sts w_sts;

    pidvi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pidvi_dp #(
        .CHANNELS  (CHANNELS),
        .FRAC_BITS (FRAC_BITS),
        .SUM_LIMIT (SUM_LIMIT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser[0]),
        .i_m_tready (i_m_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tuser  (o_m_axis_tuser),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts)
    );

endmodule

`default_nettype wire
